// ===== sv/bfx_pkg.sv =====
package bfx_pkg;

    localparam int DEF_FILTER_WORDS = 1024;
    localparam int DEF_MAX_PROBES   = 16;
    localparam int DEF_LENGTH_BITS  = 32;

    localparam int BIT_SIZE_W   = 17;
    localparam int HASH_COUNT_W = 5;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_SIZE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 1'd1;

    localparam logic [BIT_SIZE_W-1:0]   BIT_SIZE_RESET   = 17'd65536;
    localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RESET = 5'd3;

    localparam logic [3:0] WORD_BYTES = 4'd8;

    localparam logic [63:0] PR1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] PR2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] PR3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] PR4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] PR5 = 64'h27D4_EB2F_1656_67C5;

    typedef struct packed {
        logic        mode;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } word_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] h1;
        logic [63:0] h2;
    } job_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

// ===== sv/bfx_front.sv =====
module bfx_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           mode,
    input  logic [63:0]    key_word,
    input  logic [3:0]     byte_count,
    input  logic           last_word,
    output logic           full,
    output logic           word_valid,
    input  logic           word_take,
    output bfx_pkg::word_t word
);
    import bfx_pkg::*;

    word_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    word_t      entry;
    logic       take;

    // non-last words always count as full words
    always_comb
    begin
        entry.mode   = mode;
        entry.data   = key_word;
        entry.last   = last_word;
        entry.nbytes = WORD_BYTES;
        if (last_word && byte_count < WORD_BYTES)
        begin
            entry.nbytes = byte_count;
        end
    end

    assign take       = word_take && (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign word_valid = (count_reg != 2'd0);
    assign word       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ accept;
        rd_ptr_next = rd_ptr_reg ^ take;
        count_next  = count_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== sv/bfx_mul.sv =====
module bfx_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg, b_reg, lo_reg, p_reg;
    logic [31:0] x_reg;
    logic [31:0] y;
    logic [1:0]  phase_reg;
    logic        done_reg;

    // low 64 bits of the product from three 32x32 partial products
    assign y    = a_reg[63:32] * b_reg[31:0];
    assign done = done_reg;
    assign p    = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        phase_reg <= 2'd1;
                    end
                end
                2'd1: phase_reg <= 2'd2;
                2'd2: phase_reg <= 2'd3;
                2'd3:
                begin
                    phase_reg <= 2'd0;
                    done_reg  <= 1'b1;
                end
                default: phase_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && phase_reg == 2'd0)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (phase_reg == 2'd1)
        begin
            lo_reg <= 64'(a_reg[31:0]) * 64'(b_reg[31:0]);
        end
        if (phase_reg == 2'd2)
        begin
            x_reg <= a_reg[31:0] * b_reg[63:32];
        end
        if (phase_reg == 2'd3)
        begin
            p_reg <= lo_reg + {x_reg + y, 32'd0};
        end
    end

endmodule

// ===== sv/bfx_hash.sv =====
module bfx_hash #(
    parameter int LENGTH_BITS = bfx_pkg::DEF_LENGTH_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           word_valid,
    input  bfx_pkg::word_t word,
    output logic           word_take,
    output logic           job_valid,
    output bfx_pkg::job_t  job,
    input  logic           job_take
);
    import bfx_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RND_A = 5'd1;
    localparam logic [4:0] S_RND_B = 5'd2;
    localparam logic [4:0] S_START = 5'd3;
    localparam logic [4:0] S_SUM2  = 5'd4;
    localparam logic [4:0] S_SUM3  = 5'd5;
    localparam logic [4:0] S_MRG_A = 5'd6;
    localparam logic [4:0] S_MRG_B = 5'd7;
    localparam logic [4:0] S_MRG_C = 5'd8;
    localparam logic [4:0] S_LEN   = 5'd9;
    localparam logic [4:0] S_BUF_A = 5'd10;
    localparam logic [4:0] S_BUF_B = 5'd11;
    localparam logic [4:0] S_BUF_C = 5'd12;
    localparam logic [4:0] S_TAIL  = 5'd13;
    localparam logic [4:0] S_T4_A  = 5'd14;
    localparam logic [4:0] S_T4_B  = 5'd15;
    localparam logic [4:0] S_T1_A  = 5'd16;
    localparam logic [4:0] S_T1_B  = 5'd17;
    localparam logic [4:0] S_AV_A  = 5'd18;
    localparam logic [4:0] S_AV_B  = 5'd19;
    localparam logic [4:0] S_HOUT  = 5'd20;

    logic [4:0]             state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic [63:0]            lanes_reg [2][4];
    logic [63:0]            lanes_next [2][4];
    logic [63:0]            buf_reg [4];
    logic [63:0]            buf_next [4];
    logic [2:0]             bw_reg, bw_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   seen_reg, seen_next;
    logic                   last_reg, last_next;
    logic                   mode_reg, mode_next;
    logic [63:0]            tail_reg, tail_next;
    logic [3:0]             n_reg, n_next;
    logic                   seed_reg, seed_next;
    logic [2:0]             k_reg, k_next;
    logic [63:0]            tw_reg, tw_next;
    logic [3:0]             nw_reg, nw_next;
    logic [63:0]            h_reg, h_next;
    logic [63:0]            t_reg, t_next;
    logic [63:0]            h1_reg, h1_next;

    logic                   mul_state, mul_start, mul_done;
    logic [63:0]            mul_a, mul_b, mul_p;
    logic                   sel_s;
    logic [63:0]            lane_sel, fin;
    logic [LENGTH_BITS:0]   len_sum;
    logic [2:0]             bw_inc;

    bfx_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign sel_s    = (state_reg == S_RND_A || state_reg == S_RND_B) ? k_reg[2] : seed_reg;
    assign lane_sel = lanes_reg[sel_s][k_reg[1:0]];
    assign fin      = mul_p ^ (mul_p >> 32);
    assign len_sum  = {1'b0, len_reg} + (LENGTH_BITS + 1)'(word.nbytes);
    assign bw_inc   = bw_reg + 3'd1;

    assign word_take = (state_reg == S_IDLE) && word_valid;
    assign job_valid = (state_reg == S_HOUT);
    assign job.mode  = mode_reg;
    assign job.h1    = h1_reg;
    assign job.h2    = h_reg;

    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = h_reg;
        mul_b     = PR1;
        case (state_reg)
            S_RND_A: begin mul_a = buf_reg[k_reg[1:0]]; mul_b = PR2; end
            S_RND_B: mul_a = t_reg;
            S_MRG_A: begin mul_a = lane_sel; mul_b = PR2; end
            S_MRG_B: mul_a = t_reg;
            S_MRG_C: mul_a = h_reg;
            S_BUF_A: begin mul_a = buf_reg[k_reg[1:0]]; mul_b = PR2; end
            S_BUF_B: mul_a = t_reg;
            S_BUF_C: mul_a = rotl64(h_reg, 27);
            S_T4_A:  mul_a = {32'd0, tw_reg[31:0]};
            S_T4_B:  begin mul_a = rotl64(h_reg, 23); mul_b = PR2; end
            S_T1_A:  begin mul_a = {56'd0, tw_reg[7:0]}; mul_b = PR5; end
            S_T1_B:  mul_a = rotl64(h_reg, 11);
            S_AV_A:  begin mul_a = h_reg ^ (h_reg >> 33); mul_b = PR2; end
            S_AV_B:  begin mul_a = h_reg; mul_b = PR3; end
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_start = mul_state && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        lanes_next = lanes_reg;
        buf_next   = buf_reg;
        bw_next    = bw_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        last_next  = last_reg;
        mode_next  = mode_reg;
        tail_next  = tail_reg;
        n_next     = n_reg;
        seed_next  = seed_reg;
        k_next     = k_reg;
        tw_next    = tw_reg;
        nw_next    = nw_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        h1_next    = h1_reg;

        if (mul_start)
        begin
            busy_next = 1'b1;
        end
        if (mul_done)
        begin
            busy_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (word_valid)
                begin
                    len_next  = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
                    mode_next = word.mode;
                    last_next = word.last;
                    tail_next = word.data;
                    seed_next = 1'b0;
                    k_next    = 3'd0;
                    n_next    = word.nbytes;
                    state_next = word.last ? S_START : S_IDLE;
                    if (word.nbytes == WORD_BYTES)
                    begin
                        buf_next[bw_reg[1:0]] = word.data;
                        bw_next = bw_inc;
                        n_next  = 4'd0;
                        if (bw_inc == 3'd4)
                        begin
                            state_next = S_RND_A;
                        end
                    end
                end
            end
            S_RND_A:
            begin
                if (mul_done)
                begin
                    t_next     = rotl64(lane_sel + mul_p, 31);
                    state_next = S_RND_B;
                end
            end
            S_RND_B:
            begin
                if (mul_done)
                begin
                    lanes_next[k_reg[2]][k_reg[1:0]] = mul_p;
                    k_next = k_reg + 3'd1;
                    state_next = S_RND_A;
                    if (k_reg == 3'd7)
                    begin
                        seen_next  = 1'b1;
                        bw_next    = 3'd0;
                        state_next = last_reg ? S_START : S_IDLE;
                    end
                end
            end
            S_START:
            begin
                tw_next = tail_reg;
                nw_next = n_reg;
                k_next  = 3'd0;
                if (seen_reg)
                begin
                    h_next = rotl64(lanes_reg[seed_reg][0], 1)
                           + rotl64(lanes_reg[seed_reg][1], 7);
                    state_next = S_SUM2;
                end
                else
                begin
                    h_next     = {63'd0, seed_reg} + PR5;
                    state_next = S_LEN;
                end
            end
            S_SUM2:
            begin
                h_next     = h_reg + rotl64(lanes_reg[seed_reg][2], 12);
                state_next = S_SUM3;
            end
            S_SUM3:
            begin
                h_next     = h_reg + rotl64(lanes_reg[seed_reg][3], 18);
                state_next = S_MRG_A;
            end
            S_MRG_A, S_BUF_A:
            begin
                if (mul_done)
                begin
                    t_next     = rotl64(mul_p, 31);
                    state_next = (state_reg == S_MRG_A) ? S_MRG_B : S_BUF_B;
                end
            end
            S_MRG_B, S_BUF_B, S_T4_A, S_T1_A:
            begin
                if (mul_done)
                begin
                    h_next = h_reg ^ mul_p;
                    case (state_reg)
                        S_MRG_B: state_next = S_MRG_C;
                        S_BUF_B: state_next = S_BUF_C;
                        S_T4_A:  state_next = S_T4_B;
                        default: state_next = S_T1_B;
                    endcase
                end
            end
            S_MRG_C:
            begin
                if (mul_done)
                begin
                    h_next = mul_p + PR4;
                    k_next = k_reg + 3'd1;
                    state_next = (k_reg[1:0] == 2'd3) ? S_LEN : S_MRG_A;
                end
            end
            S_LEN:
            begin
                h_next     = h_reg + 64'(len_reg);
                k_next     = 3'd0;
                state_next = (bw_reg == 3'd0) ? S_TAIL : S_BUF_A;
            end
            S_BUF_C:
            begin
                if (mul_done)
                begin
                    h_next = mul_p + PR4;
                    k_next = k_reg + 3'd1;
                    state_next = ({1'b0, k_reg[1:0]} + 3'd1 == bw_reg) ? S_TAIL : S_BUF_A;
                end
            end
            S_TAIL:
            begin
                if (nw_reg >= 4'd4)
                begin
                    state_next = S_T4_A;
                end
                else if (nw_reg != 4'd0)
                begin
                    state_next = S_T1_A;
                end
                else
                begin
                    state_next = S_AV_A;
                end
            end
            S_T4_B:
            begin
                if (mul_done)
                begin
                    h_next     = mul_p + PR3;
                    tw_next    = tw_reg >> 32;
                    nw_next    = nw_reg - 4'd4;
                    state_next = S_TAIL;
                end
            end
            S_T1_B:
            begin
                if (mul_done)
                begin
                    h_next     = mul_p;
                    tw_next    = tw_reg >> 8;
                    nw_next    = nw_reg - 4'd1;
                    state_next = S_TAIL;
                end
            end
            S_AV_A:
            begin
                if (mul_done)
                begin
                    h_next     = mul_p ^ (mul_p >> 29);
                    state_next = S_AV_B;
                end
            end
            S_AV_B:
            begin
                if (mul_done)
                begin
                    if (!seed_reg)
                    begin
                        h1_next    = fin;
                        seed_next  = 1'b1;
                        state_next = S_START;
                    end
                    else
                    begin
                        h_next     = fin;
                        state_next = S_HOUT;
                    end
                end
            end
            S_HOUT:
            begin
                if (job_take)
                begin
                    lanes_next[0][0] = PR1 + PR2;
                    lanes_next[0][1] = PR2;
                    lanes_next[0][2] = 64'd0;
                    lanes_next[0][3] = 64'd0 - PR1;
                    lanes_next[1][0] = 64'd1 + PR1 + PR2;
                    lanes_next[1][1] = 64'd1 + PR2;
                    lanes_next[1][2] = 64'd1;
                    lanes_next[1][3] = 64'd1 - PR1;
                    bw_next    = 3'd0;
                    len_next   = '0;
                    seen_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            bw_reg    <= 3'd0;
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            lanes_reg[0][0] <= PR1 + PR2;
            lanes_reg[0][1] <= PR2;
            lanes_reg[0][2] <= 64'd0;
            lanes_reg[0][3] <= 64'd0 - PR1;
            lanes_reg[1][0] <= 64'd1 + PR1 + PR2;
            lanes_reg[1][1] <= 64'd1 + PR2;
            lanes_reg[1][2] <= 64'd1;
            lanes_reg[1][3] <= 64'd1 - PR1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            bw_reg    <= bw_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            lanes_reg <= lanes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        last_reg <= last_next;
        mode_reg <= mode_next;
        tail_reg <= tail_next;
        n_reg    <= n_next;
        seed_reg <= seed_next;
        k_reg    <= k_next;
        tw_reg   <= tw_next;
        nw_reg   <= nw_next;
        h_reg    <= h_next;
        t_reg    <= t_next;
        h1_reg   <= h1_next;
    end

endmodule

// ===== sv/bfx_probe.sv =====
module bfx_probe #(
    parameter int FILTER_WORDS = bfx_pkg::DEF_FILTER_WORDS,
    parameter int MAX_PROBES   = bfx_pkg::DEF_MAX_PROBES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bfx_pkg::BIT_SIZE_W-1:0]   bit_size,
    input  logic [bfx_pkg::HASH_COUNT_W-1:0] hash_count,
    input  logic                             job_valid,
    input  bfx_pkg::job_t                    job,
    output logic                             job_take,
    output logic                             clearing,
    input  logic                             pop,
    output logic                             empty,
    output logic                             present
);
    import bfx_pkg::*;

    localparam int ADDR_W   = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
    localparam int MAX_BITS = FILTER_WORDS * 64;

    localparam logic [2:0] P_CLEAR = 3'd0;
    localparam logic [2:0] P_IDLE  = 3'd1;
    localparam logic [2:0] P_DIV   = 3'd2;
    localparam logic [2:0] P_RD    = 3'd3;
    localparam logic [2:0] P_CHK   = 3'd4;
    localparam logic [2:0] P_DONE  = 3'd5;

    logic [63:0] mem [FILTER_WORDS];

    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [BIT_SIZE_W-1:0]   bs_reg, bs_next;
    logic [HASH_COUNT_W-1:0] hc_reg, hc_next;
    logic [HASH_COUNT_W-1:0] i_reg, i_next;
    logic [63:0]             h2_reg, h2_next;
    logic [63:0]             p_reg, p_next;
    logic [63:0]             d_reg, d_next;
    logic [BIT_SIZE_W-1:0]   r_reg, r_next;
    logic [3:0]              step_reg, step_next;
    logic                    all_reg, all_next;
    logic                    qmode_reg, qmode_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    present_reg, present_next;
    logic [63:0]             rd_data_reg;

    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, rd_addr;
    logic [63:0]             mem_wdata;
    logic [BIT_SIZE_W-1:0]   bs_clamp;
    logic [HASH_COUNT_W-1:0] hc_clamp;
    logic [BIT_SIZE_W:0]     rt;
    logic [BIT_SIZE_W-1:0]   r_div;
    logic [63:0]             d_div;

    always_comb
    begin
        bs_clamp = bit_size;
        if (bit_size == '0)
        begin
            bs_clamp = BIT_SIZE_W'(1);
        end
        else if (32'(bit_size) > MAX_BITS)
        begin
            bs_clamp = BIT_SIZE_W'(MAX_BITS);
        end
        hc_clamp = hash_count;
        if (32'(hash_count) > MAX_PROBES)
        begin
            hc_clamp = HASH_COUNT_W'(MAX_PROBES);
        end
    end

    // four restoring remainder steps a cycle over the 64-bit dividend
    always_comb
    begin
        r_div = r_reg;
        d_div = d_reg;
        for (int s = 0; s < 4; s++)
        begin
            rt = {r_div, d_div[63]};
            if (rt >= {1'b0, bs_reg})
            begin
                rt = rt - {1'b0, bs_reg};
            end
            r_div = rt[BIT_SIZE_W-1:0];
            d_div = d_div << 1;
        end
    end

    assign rd_addr  = ADDR_W'(r_reg >> 6);
    assign job_take = (state_reg == P_IDLE) && job_valid;
    assign clearing = (state_reg == P_CLEAR);
    assign empty    = !out_valid_reg;
    assign present  = present_reg;
    assign mem_re   = (state_reg == P_RD);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        bs_next        = bs_reg;
        hc_next        = hc_reg;
        i_next         = i_reg;
        h2_next        = h2_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        all_next       = all_reg;
        qmode_next     = qmode_reg;
        out_valid_next = out_valid_reg && !pop;
        present_next   = present_reg;
        mem_we         = 1'b0;
        mem_waddr      = rd_addr;
        mem_wdata      = rd_data_reg | (64'd1 << r_reg[5:0]);

        case (state_reg)
            P_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 64'd0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == FILTER_WORDS - 1)
                begin
                    state_next = P_IDLE;
                end
            end
            P_IDLE:
            begin
                if (job_valid)
                begin
                    bs_next    = bs_clamp;
                    hc_next    = hc_clamp;
                    h2_next    = job.h2;
                    p_next     = job.h1;
                    d_next     = job.h1;
                    r_next     = '0;
                    step_next  = 4'd0;
                    i_next     = '0;
                    all_next   = 1'b1;
                    qmode_next = job.mode;
                    state_next = (hc_clamp == '0) ? P_DONE : P_DIV;
                end
            end
            P_DIV:
            begin
                r_next    = r_div;
                d_next    = d_div;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = P_RD;
                end
            end
            P_RD: state_next = P_CHK;
            P_CHK:
            begin
                if (qmode_reg)
                begin
                    if (!rd_data_reg[r_reg[5:0]])
                    begin
                        all_next = 1'b0;
                    end
                end
                else
                begin
                    mem_we = 1'b1;
                end
                i_next     = i_reg + 1'b1;
                p_next     = p_reg + h2_reg;
                d_next     = p_reg + h2_reg;
                r_next     = '0;
                step_next  = 4'd0;
                state_next = (i_reg + 1'b1 == hc_reg) ? P_DONE : P_DIV;
            end
            P_DONE:
            begin
                if (!qmode_reg)
                begin
                    state_next = P_IDLE;
                end
                else if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    present_next   = all_reg;
                    state_next     = P_IDLE;
                end
            end
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bs_reg      <= bs_next;
        hc_reg      <= hc_next;
        i_reg       <= i_next;
        h2_reg      <= h2_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        step_reg    <= step_next;
        all_reg     <= all_next;
        qmode_reg   <= qmode_next;
        present_reg <= present_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/bloom_filter_xxh64_unit.sv =====
// Bloom filter over double XXH64 hashing (seeds 0 and 1). Keys enter as
// little-endian 64-bit words, one word per push; the last word's mode picks
// add or query, and only a query produces a result word on the output queue.
// After reset the filter memory is cleared one row per cycle with full held
// high. A non-last word that does not complete a 32-byte stripe is absorbed
// in the idle state; a word that completes a stripe runs eight lane rounds,
// two 64-bit multiplies each, on one shared multiplier. The end of a key
// runs both seeds' finish steps through the same multiplier, then each probe
// computes the 64-bit remainder by bit_size at four bits a cycle and then
// reads the memory word and sets or checks the bit. Hashing of the next key
// overlaps probing of the previous.
module bloom_filter_xxh64_unit #(
    parameter int FILTER_WORDS = bfx_pkg::DEF_FILTER_WORDS,
    parameter int MAX_PROBES   = bfx_pkg::DEF_MAX_PROBES,
    parameter int LENGTH_BITS  = bfx_pkg::DEF_LENGTH_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            mode,
    input  logic [63:0]                     key_word,
    input  logic [3:0]                      byte_count,
    input  logic                            last_word,
    output logic                            empty,
    input  logic                            pop,
    output logic                            present,
    input  logic                            cfg_we,
    input  logic [bfx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bfx_pkg::*;

    logic [BIT_SIZE_W-1:0]   bit_size_reg;
    logic [HASH_COUNT_W-1:0] hash_count_reg;
    logic                    front_full, clearing, accept;
    logic                    word_valid, word_take, job_valid, job_take;
    word_t                   word;
    job_t                    job;

    assign full   = front_full || clearing;
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_size_reg   <= BIT_SIZE_RESET;
            hash_count_reg <= HASH_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_SIZE:   bit_size_reg   <= cfg_data[BIT_SIZE_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= cfg_data[HASH_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    bfx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .key_word   (key_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .full       (front_full),
        .word_valid (word_valid),
        .word_take  (word_take),
        .word       (word)
    );

    bfx_hash #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take),
        .job_valid  (job_valid),
        .job        (job),
        .job_take   (job_take)
    );

    bfx_probe #(
        .FILTER_WORDS (FILTER_WORDS),
        .MAX_PROBES   (MAX_PROBES)
    ) u_probe (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_size   (bit_size_reg),
        .hash_count (hash_count_reg),
        .job_valid  (job_valid),
        .job        (job),
        .job_take   (job_take),
        .clearing   (clearing),
        .pop        (pop),
        .empty      (empty),
        .present    (present)
    );

endmodule

// ===== sv/bfx_checker.sv =====
module bfx_checker (
    input logic clk,
    input logic rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic present
);

    // memory clear pass holds off input right after reset
    a_full_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("full low while the filter is still clearing");

    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result word shown right after reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result word dropped");

    a_present_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(present))
        else $error("waiting result word changed");

endmodule

bind bloom_filter_xxh64_unit bfx_checker u_chk (.*);

// ===== test/bloom_filter_xxh64_unit_tb.sv =====
`timescale 1ns / 100ps

module bloom_filter_xxh64_unit_tb;
    import bfx_pkg::*;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   STORE_ROWS = 1024;
    localparam int   PROBE_MAX  = 16;
    localparam logic [63:0] LEN_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int   POOL_KEYS  = 24;
    localparam int   KEY_WORDS  = 12;
    localparam int   DRAIN_WAIT = 2500;

    typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        logic            m;
        logic [63:0]     d;
        logic [3:0]      bc;
        logic            lw;
        bit              typed;
        logic            p;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic                   mode;
    logic [63:0]            key_word;
    logic [3:0]             byte_count;
    logic                   last_word;
    logic                   empty;
    logic                   pop;
    logic                   present;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // expectation typed into the stimulus table, travels with the word
    bit   typed_row;
    logic typed_present;

    // predictor state
    logic [63:0] bloom_bits [STORE_ROWS];
    logic [63:0] lane [2][4];
    logic [63:0] stripe [4];
    int unsigned stripe_fill;
    logic [63:0] key_len;
    bit          stripe_done;
    logic [16:0] cur_bit_size;
    logic [4:0]  cur_hash_count;

    logic present_q [$];
    int   errors;
    int   burst_left;
    bit   no_gaps;
    int unsigned cyc;
    row_t rows [$];

    logic [63:0] pool_w [POOL_KEYS][KEY_WORDS];
    int          pool_nw [POOL_KEYS];
    int          pool_nb [POOL_KEYS];

    bloom_filter_xxh64_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .key_word   (key_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .empty      (empty),
        .pop        (pop),
        .present    (present),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
        if (r == 0)
            return x;
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] xx_round(input logic [63:0] acc, input logic [63:0] in);
        logic [63:0] a;
        a = acc + in * PR2;
        return rol64(a, 31) * PR1;
    endfunction

    function automatic void new_key();
        for (int s = 0; s < 2; s++)
        begin
            lane[s][0] = 64'(s) + PR1 + PR2;
            lane[s][1] = 64'(s) + PR2;
            lane[s][2] = 64'(s);
            lane[s][3] = 64'(s) - PR1;
        end
        stripe_fill = 0;
        key_len     = '0;
        stripe_done = 1'b0;
    endfunction

    function automatic void clear_filter_model();
        for (int r = 0; r < STORE_ROWS; r++)
            bloom_bits[r] = '0;
        for (int j = 0; j < 4; j++)
            stripe[j] = '0;
        cur_bit_size   = BIT_SIZE_RESET;
        cur_hash_count = HASH_COUNT_RESET;
        new_key();
    endfunction

    function automatic logic [63:0] key_digest(input int s, input logic [63:0] tail_in,
                                               input int unsigned nb_in);
        logic [63:0] h;
        logic [63:0] tail;
        int unsigned nb;
        tail = tail_in;
        nb   = nb_in;
        if (stripe_done)
        begin
            h = rol64(lane[s][0], 1) + rol64(lane[s][1], 7) + rol64(lane[s][2], 12)
                + rol64(lane[s][3], 18);
            for (int j = 0; j < 4; j++)
            begin
                h ^= xx_round(64'd0, lane[s][j]);
                h = h * PR1 + PR4;
            end
        end
        else
            h = 64'(s) + PR5;
        h += key_len;
        for (int j = 0; j < stripe_fill && j < 4; j++)
        begin
            h ^= xx_round(64'd0, stripe[j]);
            h = rol64(h, 27) * PR1 + PR4;
        end
        if (nb >= 4)
        begin
            h ^= {32'd0, tail[31:0]} * PR1;
            h = rol64(h, 23) * PR2 + PR3;
            tail = tail >> 32;
            nb -= 4;
        end
        while (nb > 0)
        begin
            h ^= {56'd0, tail[7:0]} * PR5;
            h = rol64(h, 11) * PR1;
            tail = tail >> 8;
            nb--;
        end
        h ^= h >> 33;
        h *= PR2;
        h ^= h >> 29;
        h *= PR3;
        h ^= h >> 32;
        return h;
    endfunction

    // absorbs one key word; returns 1 when a query answer is due
    function automatic bit absorb_word(input logic m, input logic [63:0] d, input logic [3:0] bc,
                                       input logic lw, output logic hit);
        int unsigned n;
        logic [63:0] h1, h2, bs, hc, idx;
        hit = 1'b1;
        n = 8;
        if (lw)
            n = (bc > 4'd8) ? 8 : int'(bc);
        if (LEN_MAX - key_len < 64'(n))
            key_len = LEN_MAX;
        else
            key_len += 64'(n);
        if (n == 8)
        begin
            stripe[stripe_fill & 3] = d;
            stripe_fill++;
            if (stripe_fill >= 4)
            begin
                for (int s = 0; s < 2; s++)
                    for (int j = 0; j < 4; j++)
                        lane[s][j] = xx_round(lane[s][j], stripe[j]);
                stripe_done = 1'b1;
                stripe_fill = 0;
            end
            n = 0;
        end
        if (!lw)
            return 1'b0;
        h1 = key_digest(0, d, n);
        h2 = key_digest(1, d, n);
        new_key();
        bs = 64'(cur_bit_size);
        if (bs == 0)
            bs = 1;
        if (bs > 64'(STORE_ROWS * 64))
            bs = 64'(STORE_ROWS * 64);
        hc = 64'(cur_hash_count);
        if (hc > 64'(PROBE_MAX))
            hc = 64'(PROBE_MAX);
        for (logic [63:0] i = 0; i < hc; i++)
        begin
            idx = (h1 + i * h2) % bs;
            if (m == MODE_QUERY)
            begin
                if (!bloom_bits[idx[15:6]][idx[5:0]])
                    hit = 1'b0;
            end
            else
                bloom_bits[idx[15:6]][idx[5:0]] = 1'b1;
        end
        return (m == MODE_QUERY);
    endfunction

    // accepted words and answers, both taken at the clock edge
    always @(posedge clk)
    begin
        logic hit;
        logic want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (absorb_word(mode, key_word, byte_count, last_word, hit))
                    present_q.push_back(typed_row ? typed_present : hit);
            end
            if (pop && !empty)
            begin
                if (present_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected answer word, present=%0b", $time, present);
                end
                else
                begin
                    want = present_q.pop_front();
                    if (present !== want)
                    begin
                        errors++;
                        $display("%0t: present mismatch, expected %0b actual %0b",
                                 $time, want, present);
                    end
                end
            end
        end
    end

    // receiver stalls on a pattern that rotates through four modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            cyc <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            case ((cyc / 300) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ((cyc % 5) < 3);
            endcase
        end
    end

    task automatic send_word(input logic m, input logic [63:0] d, input logic [3:0] bc,
                             input logic lw, input bit typed, input logic p);
        push          <= 1'b1;
        mode          <= m;
        key_word      <= d;
        byte_count    <= bc;
        last_word     <= lw;
        typed_row     <= typed;
        typed_present <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!no_gaps && burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (present_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        // adds leave no answer behind, so give the probe pipeline time to finish
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BIT_SIZE)
            cur_bit_size = val[16:0];
        else
            cur_hash_count = val[4:0];
    endtask

    function automatic void tab_word(input logic m, input logic [63:0] d, input logic [3:0] bc,
                                     input logic lw, input bit typed = 0, input logic p = 0);
        row_t r;
        r = '{kind: ROW_WORD, m: m, d: d, bc: bc, lw: lw, typed: typed, p: p,
              idx: '0, val: '0};
        rows.push_back(r);
    endfunction

    function automatic void tab_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '{kind: ROW_CFG, m: 0, d: 0, bc: 0, lw: 0, typed: 0, p: 0, idx: idx, val: val};
        rows.push_back(r);
    endfunction

    function automatic void make_key(input int slot);
        pool_nw[slot] = ($urandom_range(0, 4) == 0) ? $urandom_range(5, KEY_WORDS)
                                                    : $urandom_range(1, 4);
        pool_nb[slot] = $urandom_range(0, 15);
        for (int w = 0; w < KEY_WORDS; w++)
            pool_w[slot][w] = {$urandom, $urandom};
    endfunction

    task automatic send_key(input int slot, input logic m);
        logic lw;
        for (int w = 0; w < pool_nw[slot]; w++)
        begin
            lw = (w == pool_nw[slot] - 1);
            // mode and byte count of a non-last word do not matter
            send_word(lw ? m : logic'($urandom_range(0, 1)), pool_w[slot][w],
                      lw ? 4'(pool_nb[slot]) : 4'($urandom_range(0, 15)), lw, 0, 0);
        end
    endtask

    initial
    begin
        int sent;
        int slot;
        logic [CFG_DATA_W-1:0] bs_set [6];
        logic [CFG_DATA_W-1:0] hc_set [6];
        rst_n         = 1'b0;
        push          <= 1'b0;
        mode          <= MODE_ADD;
        key_word      <= '0;
        byte_count    <= '0;
        last_word     <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        typed_row     <= 1'b0;
        typed_present <= 1'b0;
        errors     = 0;
        burst_left = 0;
        no_gaps    = 0;
        clear_filter_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty filter answers no
        tab_word(MODE_QUERY, 64'd0, 4'd0, 1'b1, 1, 1'b0);
        tab_word(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1, 1'b0);
        tab_word(MODE_ADD, 64'd0, 4'd0, 1'b1);
        tab_word(MODE_QUERY, 64'h1234, 4'd0, 1'b1);
        tab_word(MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        tab_word(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        // long key: one full stripe then a tail word, junk byte counts before the end
        tab_word(MODE_QUERY, 64'hAAAA_5555_AAAA_5555, 4'd0, 1'b0);
        tab_word(MODE_ADD, 64'h5555_AAAA_5555_AAAA, 4'd3, 1'b0);
        tab_word(MODE_QUERY, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b0);
        tab_word(MODE_ADD, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b0);
        tab_word(MODE_ADD, 64'h0000_00FF_0000_00FF, 4'd5, 1'b1);
        tab_word(MODE_ADD, 64'hAAAA_5555_AAAA_5555, 4'd8, 1'b0);
        tab_word(MODE_ADD, 64'h5555_AAAA_5555_AAAA, 4'd8, 1'b0);
        tab_word(MODE_ADD, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
        tab_word(MODE_ADD, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b0);
        tab_word(MODE_QUERY, 64'h0000_00FF_0000_00FF, 4'd5, 1'b1);
        // no probes: nothing changes, every query answers yes
        tab_cfg(REG_HASH_COUNT, 17'd0);
        tab_word(MODE_QUERY, 64'h0BAD_F00D, 4'd4, 1'b1, 1, 1'b1);
        tab_word(MODE_ADD, 64'h0BAD_F00D, 4'd4, 1'b1);
        // zero filter size acts as one bit
        tab_cfg(REG_HASH_COUNT, 17'd2);
        tab_cfg(REG_BIT_SIZE, 17'd0);
        tab_word(MODE_ADD, 64'h77, 4'd1, 1'b1);
        tab_word(MODE_QUERY, 64'h9999, 4'd2, 1'b1);
        // oversize filter and probe count clamp
        tab_cfg(REG_BIT_SIZE, 17'h1FFFF);
        tab_cfg(REG_HASH_COUNT, 17'h1FFFF);
        tab_word(MODE_ADD, 64'hC0FF_EE00_C0FF_EE00, 4'd7, 1'b1);
        tab_word(MODE_QUERY, 64'hC0FF_EE00_C0FF_EE00, 4'd7, 1'b1);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_word(rows[i].m, rows[i].d, rows[i].bc, rows[i].lw,
                          rows[i].typed, rows[i].p);
        end

        bs_set = '{17'd65536, 17'd64, 17'd1, 17'd4096, 17'h1FFFF,
                   17'($urandom_range(2, 3000))};
        hc_set = '{17'd3, 17'd4, 17'd1, 17'd16, 17'd31, 17'($urandom_range(1, 8))};
        for (int k = 0; k < POOL_KEYS; k++)
            make_key(k);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BIT_SIZE, bs_set[ph]);
            write_reg(REG_HASH_COUNT, hc_set[ph]);
            no_gaps = (ph == 3);
            sent = 0;
            while (sent < 280)
            begin
                slot = $urandom_range(0, POOL_KEYS - 1);
                if ($urandom_range(0, 9) < 2)
                    make_key(slot);
                send_key(slot, ($urandom_range(0, 19) < 9) ? MODE_ADD : MODE_QUERY);
                sent += pool_nw[slot];
                if (ph == 1 && sent >= 140 && sent < 140 + pool_nw[slot])
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && present_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
